// ----- rtl/nta_pkg.sv -----
// Package with the request, response and command types and the constants of the ASCII number formatter.
package nta_pkg;

   localparam logic [2:0] FUNC_SDEC = 3'd0;
   localparam logic [2:0] FUNC_UDEC = 3'd1;
   localparam logic [2:0] FUNC_UHEX = 3'd2;
   localparam logic [2:0] FUNC_OCT  = 3'd3;
   localparam logic [2:0] FUNC_PTR  = 3'd4;

   localparam logic [7:0] ASCII_ZERO   = 8'd48;
   localparam logic [7:0] UPPER_OFFSET = 8'd55;
   localparam logic [7:0] LOWER_OFFSET = 8'd87;
   localparam logic [7:0] CHAR_MINUS   = 8'd45;
   localparam logic [7:0] CHAR_X       = 8'd120;

   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          QUOT_W      = 64 - RECIP_SHIFT;

   localparam int MAX_DIGITS  = 16;
   localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
   localparam int DIGIT_CNT_W = DIGIT_IDX_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] value;
   } nta_req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } nta_rsp_type;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_HEX,
      RADIX_OCT
   } nta_radix_type;

   typedef struct packed {
      logic [63:0]   mag;
      nta_radix_type radix;
      logic          lower;
      logic          minus;
      logic          prefix;
   } nta_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } nta_qstat_type;

   typedef struct packed {
      logic                   busy;
      logic [DIGIT_CNT_W-1:0] digit_count;
   } nta_bstat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_REM,
      ST_SHIFT,
      ST_SIGN,
      ST_PFX0,
      ST_PFXX,
      ST_DIGIT
   } nta_state_type;

endpackage

// ----- rtl/nta_front.sv -----
// Front end that accepts requests and turns each into a conversion command.
module nta_front
   import nta_pkg::*;
(
   input  logic          req_valid,
   output logic          req_stall,
   input  nta_req_type   req_data,
   input  nta_qstat_type qstat,
   output logic          push,
   output nta_cmd_type   cmd
);

   logic        code_ok;
   logic [31:0] low;

   assign low       = req_data.value[31:0];
   assign req_stall = qstat.full;

   always_comb begin
      cmd        = '0;
      cmd.radix  = RADIX_DEC;
      cmd.mag    = {32'd0, low};
      code_ok    = 1'b1;
      case (req_data.func)
         FUNC_SDEC: begin
            cmd.minus = low[31];
            if (low[31]) begin
               cmd.mag = {32'd0, ~low + 32'd1};
            end
         end
         FUNC_UDEC: begin
            cmd.radix = RADIX_DEC;
         end
         FUNC_UHEX: begin
            cmd.radix = RADIX_HEX;
         end
         FUNC_OCT: begin
            cmd.radix = RADIX_OCT;
         end
         FUNC_PTR: begin
            cmd.radix  = RADIX_HEX;
            cmd.mag    = req_data.value;
            cmd.lower  = 1'b1;
            cmd.prefix = 1'b1;
         end
         default: begin
            code_ok = 1'b0;
         end
      endcase
   end

   // Requests with an unused code are accepted and dropped here.
   assign push = req_valid && !qstat.full && code_ok;

endmodule

// ----- rtl/nta_queue.sv -----
// Short command queue between the front end and the conversion engine.
module nta_queue
   import nta_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  nta_cmd_type   push_cmd,
   input  logic          pop,
   output nta_cmd_type   head_cmd,
   output nta_qstat_type qstat
);

   nta_cmd_type            entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign head_cmd    = entries_ff[rd_ptr_ff];
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/nta_back.sv -----
// Conversion engine that extracts the digits and emits the characters one per cycle while rsp_stall is low.
module nta_back
   import nta_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  nta_cmd_type   head_cmd,
   input  nta_qstat_type qstat,
   output logic          pop,
   output nta_bstat_type bstat,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output nta_rsp_type   rsp_data
);

   nta_state_type          state_ff;
   nta_state_type          state_in;
   logic [63:0]            mag_ff;
   logic [63:0]            prod_ff;
   logic [3:0]             digits_ff [MAX_DIGITS];
   logic [DIGIT_CNT_W-1:0] cnt_ff;
   nta_radix_type          radix_ff;
   logic                   lower_ff;
   logic                   minus_ff;
   logic                   prefix_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   nta_rsp_type            rsp_data_ff;

   logic                   out_free;
   logic                   emit;
   logic [7:0]             emit_char;
   logic                   emit_last;
   logic [QUOT_W-1:0]      quot;
   logic [31:0]            quot_x10;
   logic [31:0]            rem;
   logic [63:0]            shifted;
   logic [3:0]             shift_digit;
   logic [DIGIT_CNT_W-1:0] cnt_m1;
   logic [3:0]             cur_digit;
   logic [7:0]             digit_char;
   nta_state_type          emit_start;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      quot     = prod_ff[63:RECIP_SHIFT];
      quot_x10 = ({{(32 - QUOT_W){1'b0}}, quot} << 3) + ({{(32 - QUOT_W){1'b0}}, quot} << 1);
      rem      = mag_ff[31:0] - quot_x10;
      if (radix_ff == RADIX_OCT) begin
         shifted     = mag_ff >> 3;
         shift_digit = {1'b0, mag_ff[2:0]};
      end else begin
         shifted     = mag_ff >> 4;
         shift_digit = mag_ff[3:0];
      end
      cnt_m1    = cnt_ff - 1'b1;
      cur_digit = digits_ff[cnt_m1[DIGIT_IDX_W-1:0]];
      if (cur_digit >= 4'd10) begin
         digit_char = {4'd0, cur_digit} + (lower_ff ? LOWER_OFFSET : UPPER_OFFSET);
      end else begin
         digit_char = {4'd0, cur_digit} + ASCII_ZERO;
      end
      if (minus_ff) begin
         emit_start = ST_SIGN;
      end else if (prefix_ff) begin
         emit_start = ST_PFX0;
      end else begin
         emit_start = ST_DIGIT;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               state_in = (head_cmd.radix == RADIX_DEC) ? ST_MUL : ST_SHIFT;
            end
         end
         ST_MUL: begin
            state_in = ST_REM;
         end
         ST_REM: begin
            state_in = (quot == '0) ? emit_start : ST_MUL;
         end
         ST_SHIFT: begin
            if (shifted == '0) begin
               state_in = emit_start;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_PFX0: begin
            if (out_free) begin
               state_in = ST_PFXX;
            end
         end
         ST_PFXX: begin
            if (out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free && cnt_ff == DIGIT_CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      emit_char = digit_char;
      emit_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            pop = !qstat.empty;
         end
         ST_SIGN: begin
            emit      = out_free;
            emit_char = CHAR_MINUS;
         end
         ST_PFX0: begin
            emit      = out_free;
            emit_char = ASCII_ZERO;
         end
         ST_PFXX: begin
            emit      = out_free;
            emit_char = CHAR_X;
         end
         ST_DIGIT: begin
            emit      = out_free;
            emit_last = (cnt_ff == DIGIT_CNT_W'(1));
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  cnt_ff <= '0;
               end
            end
            ST_REM: begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            ST_SHIFT: begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            ST_DIGIT: begin
               if (emit) begin
                  cnt_ff <= cnt_m1;
               end
            end
            default: begin
               cnt_ff <= cnt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               mag_ff    <= head_cmd.mag;
               radix_ff  <= head_cmd.radix;
               lower_ff  <= head_cmd.lower;
               minus_ff  <= head_cmd.minus;
               prefix_ff <= head_cmd.prefix;
            end
         end
         ST_MUL: begin
            prod_ff <= mag_ff[31:0] * RECIP_TEN;
         end
         ST_REM: begin
            digits_ff[cnt_ff[DIGIT_IDX_W-1:0]] <= rem[3:0];
            mag_ff <= {{(64 - QUOT_W){1'b0}}, quot};
         end
         ST_SHIFT: begin
            digits_ff[cnt_ff[DIGIT_IDX_W-1:0]] <= shift_digit;
            mag_ff <= shifted;
         end
         default: begin
            mag_ff <= mag_ff;
         end
      endcase
      if (emit) begin
         rsp_data_ff.char_out <= emit_char;
         rsp_data_ff.last     <= emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;
   assign bstat.busy        = (state_ff != ST_IDLE);
   assign bstat.digit_count = cnt_ff;

endmodule

// ----- rtl/number_to_ascii_formatter.sv -----
// Top level of the formatter that prints a number as a stream of ASCII characters.
//
// A request carries a conversion code and a 64-bit value on req_data; it is taken
// at a clock edge where req_valid is high and req_stall is low. Each response on
// rsp_data is one character, most significant first, and the final character of
// a number has last set. Signed and unsigned decimal, upper-case hex and octal
// use the low 32 bits; the pointer code prints 0x and lower-case hex of 64 bits.
// A request with an unused code is taken and produces no characters.
// Accepted requests enter a two-entry command queue, so the front end keeps
// taking requests while the engine works. The engine extracts hex and octal
// digits at one per cycle, and decimal digits through a multiply state and a
// remainder state per digit, using a reciprocal multiply by one tenth; it then
// sends one character per cycle while rsp_stall is low.
// When rsp_stall is high the output register holds its character and the engine
// waits; req_stall rises once the queue is full. Reset empties the queue and
// drops any character in flight.
module number_to_ascii_formatter
   import nta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  nta_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output nta_rsp_type rsp_data
);

   nta_qstat_type qstat;
   nta_bstat_type bstat;
   nta_cmd_type   push_cmd;
   nta_cmd_type   head_cmd;
   logic          push;
   logic          pop;

   nta_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .cmd       (push_cmd)
   );

   nta_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   nta_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .qstat     (qstat),
      .pop       (pop),
      .bstat     (bstat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset) pop |-> !qstat.empty)
      else $error("Engine took a command from an empty queue.");

   assert property (@(posedge clock) disable iff (reset) push |-> !qstat.full)
      else $error("Front end wrote into a full queue.");

   assert property (@(posedge clock) disable iff (reset)
                    bstat.digit_count <= DIGIT_CNT_W'(MAX_DIGITS))
      else $error("Digit count exceeds the digit buffer.");

   assert property (@(posedge clock) disable iff (reset) pop |=> bstat.busy)
      else $error("Engine did not start on a taken command.");

endmodule

// ----- dv/tb_number_to_ascii_formatter.sv -----
// Self-checking testbench for the ASCII number formatter: directed table, random requests, predictor.
`timescale 1ns / 100ps

module tb_number_to_ascii_formatter;
   import nta_pkg::*;

   localparam int          CYCLE_LIMIT  = 600000;
   localparam int          RANDOM_ITEMS = 300;
   localparam int          QUIET_ITEMS  = 40;
   localparam int          DRAIN_CYCLES = 60;
   localparam logic [2:0]  FUNC_TOP     = '1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   nta_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   nta_rsp_type rsp_data;

   nta_rsp_type expected_chars[$];
   int          mismatch_count = 0;
   bit          quiet = 0;
   bit          cur_typed = 0;
   string       cur_text = "";

   logic [2:0]  row_func[$];
   logic [63:0] row_value[$];
   bit          row_typed[$];
   string       row_text[$];

   number_to_ascii_formatter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void push_char(input logic [7:0] ch, input logic is_last);
      nta_rsp_type item;
      item.char_out = ch;
      item.last     = is_last;
      expected_chars.push_back(item);
   endfunction

   function automatic void predict_chars(input nta_req_type r);
      logic [63:0] mag;
      logic [31:0] low;
      int unsigned radix;
      logic [7:0]  letter_base;
      bit          minus;
      bit          prefix;
      logic [3:0]  digit_buf[18];
      int          nd;
      minus       = 1'b0;
      prefix      = 1'b0;
      letter_base = UPPER_OFFSET;
      radix       = 10;
      mag         = {32'd0, r.value[31:0]};
      nd          = 0;
      case (r.func)
         FUNC_SDEC: begin
            if (r.value[31]) begin
               minus = 1'b1;
               low   = -r.value[31:0];
               mag   = {32'd0, low};
            end
         end
         FUNC_UDEC: radix = 10;
         FUNC_UHEX: radix = 16;
         FUNC_OCT:  radix = 8;
         FUNC_PTR: begin
            mag         = r.value;
            radix       = 16;
            letter_base = LOWER_OFFSET;
            prefix      = 1'b1;
         end
         default: return;
      endcase
      do begin
         digit_buf[nd] = 4'(mag % radix);
         mag = mag / radix;
         nd++;
      end while (mag != 0);
      if (minus) push_char(CHAR_MINUS, 1'b0);
      if (prefix) begin
         push_char(ASCII_ZERO, 1'b0);
         push_char(CHAR_X, 1'b0);
      end
      for (int i = nd - 1; i >= 0; i--) begin
         if (digit_buf[i] >= 4'd10) push_char(letter_base + 8'(digit_buf[i]), i == 0);
         else push_char(ASCII_ZERO + 8'(digit_buf[i]), i == 0);
      end
   endfunction

   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = {$urandom, 32'($urandom_range(0, 999))};
         2: v = {$urandom, 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd2};
         3: v = {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(0, 3))};
         4: begin
            v = 64'd1 << $urandom_range(0, 63);
            if ($urandom_range(0, 1) == 1) v = v - 64'd1;
         end
         default: v = {32'($urandom_range(0, 255)), $urandom};
      endcase
      return v;
   endfunction

   task automatic add_row(input logic [2:0] f, input logic [63:0] v, input bit typed,
                          input string text);
      row_func.push_back(f);
      row_value.push_back(v);
      row_typed.push_back(typed);
      row_text.push_back(text);
   endtask

   task automatic send_request(input logic [2:0] f, input logic [63:0] v, input bit typed,
                               input string text);
      nta_req_type r;
      r.func  = f;
      r.value = v;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      cur_typed = typed;
      cur_text  = text;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sender_gap(inout int calm_items);
      int n;
      if (calm_items > 0) begin
         calm_items--;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
         n = $urandom_range(1, 13);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end else if ($urandom_range(0, 29) == 0) begin
         calm_items = 20;
      end
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   initial begin
      int burst;
      int calm;
      calm = 0;
      forever begin
         @(negedge clock);
         if (!quiet && calm == 0 && $urandom_range(0, 2) == 0) begin
            burst = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         if (calm > 0) calm--;
         else if ($urandom_range(0, 59) == 0) calm = 80;
      end
   end

   always @(posedge clock) begin
      nta_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected character, expected none, actual char %h last %b",
                        $time, rsp_data.char_out, rsp_data.last);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.char_out !== want.char_out) begin
                  mismatch_count++;
                  $display("%0t: char_out expected %h actual %h", $time, want.char_out,
                           rsp_data.char_out);
               end
               if (rsp_data.last !== want.last) begin
                  mismatch_count++;
                  $display("%0t: last expected %b actual %b", $time, want.last,
                           rsp_data.last);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (cur_typed) begin
               for (int i = 0; i < cur_text.len(); i++)
                  push_char(cur_text[i], i == cur_text.len() - 1);
            end else begin
               predict_chars(req_data);
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("number_to_ascii_formatter: mismatch");
      $finish;
   end

   initial begin
      int sent;
      int calm_items;
      logic [2:0] f;
      reset     = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_data  = '0;
      sent       = 0;
      calm_items = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(FUNC_SDEC, 64'd0, 1'b1, "0");
      add_row(FUNC_SDEC, 64'h0000_0000_8000_0000, 1'b1, "-2147483648");
      add_row(FUNC_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b1, "2147483647");
      add_row(FUNC_SDEC, 64'h0000_0000_FFFF_FFFF, 1'b1, "-1");
      add_row(FUNC_SDEC, 64'hFFFF_FFFF_0000_0005, 1'b1, "5");
      add_row(FUNC_SDEC, 64'h0000_0000_8765_4321, 1'b0, "");
      add_row(FUNC_UDEC, 64'd0, 1'b1, "0");
      add_row(FUNC_UDEC, 64'h0000_0000_FFFF_FFFF, 1'b1, "4294967295");
      add_row(FUNC_UDEC, 64'hFFFF_FFFF_8000_0000, 1'b1, "2147483648");
      add_row(FUNC_UDEC, 64'h0000_0000_1234_5678, 1'b0, "");
      add_row(FUNC_UHEX, 64'd0, 1'b1, "0");
      add_row(FUNC_UHEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "FFFFFFFF");
      add_row(FUNC_UHEX, 64'h0123_4567_89AB_CDEF, 1'b0, "");
      add_row(FUNC_OCT,  64'd0, 1'b1, "0");
      add_row(FUNC_OCT,  64'h0000_0000_FFFF_FFFF, 1'b1, "37777777777");
      add_row(FUNC_OCT,  64'h0000_0000_0000_0008, 1'b1, "10");
      add_row(FUNC_PTR,  64'd0, 1'b1, "0x0");
      add_row(FUNC_PTR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "0xffffffffffffffff");
      add_row(FUNC_PTR,  64'h8000_0000_0000_0000, 1'b1, "0x8000000000000000");
      add_row(FUNC_PTR,  64'h0000_0000_00AB_CDEF, 1'b0, "");
      add_row(FUNC_PTR + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "");
      add_row(FUNC_PTR + 3'd2, 64'd0, 1'b1, "");
      add_row(FUNC_TOP, 64'h5555_AAAA_5555_AAAA, 1'b1, "");
      add_row(FUNC_SDEC, 64'd9, 1'b1, "9");

      for (int i = 0; i < row_func.size(); i++) begin
         send_request(row_func[i], row_value[i], row_typed[i], row_text[i]);
         sender_gap(calm_items);
      end
      wait_for_drain();

      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            f = 3'($urandom_range(int'(FUNC_PTR) + 1, int'(FUNC_TOP)));
            send_request(f, {$urandom, $urandom}, 1'b0, "");
         end else begin
            f = 3'($urandom_range(int'(FUNC_SDEC), int'(FUNC_PTR)));
            send_request(f, random_operand(), 1'b0, "");
            sent++;
            if (sent == RANDOM_ITEMS / 2) wait_for_drain();
         end
         quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
         sender_gap(calm_items);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("number_to_ascii_formatter: match");
      end else begin
         $display("number_to_ascii_formatter: mismatch");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/nta_pkg.sv
rtl/nta_front.sv
rtl/nta_queue.sv
rtl/nta_back.sv
rtl/number_to_ascii_formatter.sv
dv/tb_number_to_ascii_formatter.sv
